[rtl/ivs_pkg.sv]
// ivs_pkg: shared constants, codes and controller/datapath command and status
// types for the indexed vector store. No dependencies.
`timescale 1ns / 1ps

package ivs_pkg;

  // Store geometry and field widths
  localparam int CAPACITY = 64;
  localparam int WORD_W   = 32;
  localparam int OP_W     = 4;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ST_W     = 2;

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  // Operation codes
  localparam logic [OP_W-1:0] OP_GET        = 4'd0;
  localparam logic [OP_W-1:0] OP_SET        = 4'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd2;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd4;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd5;
  localparam logic [OP_W-1:0] OP_DELETE     = 4'd6;
  localparam logic [OP_W-1:0] OP_FIND       = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // Memory address selection
  localparam logic [2:0] ADDR_POS    = 3'd0;
  localparam logic [2:0] ADDR_IDX    = 3'd1;
  localparam logic [2:0] ADDR_IDX_DN = 3'd2;
  localparam logic [2:0] ADDR_IDX_UP = 3'd3;
  localparam logic [2:0] ADDR_COUNT  = 3'd4;
  localparam logic [2:0] ADDR_LAST   = 3'd5;
  localparam logic [2:0] ADDR_ZERO   = 3'd6;

  // Walk index load source
  localparam logic [1:0] IDX_FROM_POS   = 2'd0;
  localparam logic [1:0] IDX_FROM_COUNT = 2'd1;
  localparam logic [1:0] IDX_FROM_ZERO  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic            latch;
    logic            mem_rd;
    logic            mem_wr;
    logic [2:0]      addr_sel;
    logic            wr_from_rd;
    logic            idx_ld;
    logic [1:0]      idx_sel;
    logic            idx_inc;
    logic            idx_dec;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            cnt_clr;
    logic            cap_word;
    logic            set_st;
    logic [ST_W-1:0] st;
    logic            set_at;
    logic            out_load;
  } ivs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pos_ok;
    logic            empty;
    logic            full;
    logic            idx_zero;
    logic            idx_last;
    logic            idx_end;
    logic            match;
    logic            out_busy;
  } ivs_sts_t;

endpackage

[rtl/indexed_vector_store.sv]
// indexed_vector_store: fixed-capacity ordered word store, one word a time.
// Clear, set, push-back, unused codes and refused items finish at decode; get and
// pop-back read one entry; push-front shifts every entry up one place; delete and
// pop-front shift the entries above the removed one down one place; find reads entries
// from index zero until the first match or the end. One item at a time, so a stalled
// result holds off the next word. Reset (rst_n low, synchronous) empties the store.
`timescale 1ns / 1ps

module indexed_vector_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ivs_pkg::OP_W-1:0]    in_op,
  input  logic [ivs_pkg::IDX_W-1:0]   in_position,
  input  logic [ivs_pkg::WORD_W-1:0]  in_word_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ivs_pkg::WORD_W-1:0]  out_word_out,
  output logic [ivs_pkg::IDX_W-1:0]   out_found_at,
  output logic [ivs_pkg::ST_W-1:0]    out_status,
  output logic [ivs_pkg::CNT_W-1:0]   out_live_count
);

  ivs_pkg::ivs_cmd_t cmd;
  ivs_pkg::ivs_sts_t sts;

  // Sequencer
  ivs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memory, count and result path
  ivs_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_word_in     (in_word_in),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_out   (out_word_out),
    .out_found_at   (out_found_at),
    .out_status     (out_status),
    .out_live_count (out_live_count)
  );

endmodule

[rtl/ivs_datapath.sv]
// ivs_datapath: entry memory, live count, walk index, result and output
// registers of the indexed vector store. Depends on ivs_pkg.
`timescale 1ns / 1ps

module ivs_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ivs_pkg::OP_W-1:0]    in_op,
  input  logic [ivs_pkg::IDX_W-1:0]   in_position,
  input  logic [ivs_pkg::WORD_W-1:0]  in_word_in,
  input  ivs_pkg::ivs_cmd_t           cmd,
  output ivs_pkg::ivs_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ivs_pkg::WORD_W-1:0]  out_word_out,
  output logic [ivs_pkg::IDX_W-1:0]   out_found_at,
  output logic [ivs_pkg::ST_W-1:0]    out_status,
  output logic [ivs_pkg::CNT_W-1:0]   out_live_count
);

  logic [ivs_pkg::WORD_W-1:0] mem [ivs_pkg::CAPACITY];

  logic [ivs_pkg::OP_W-1:0]   op_r;
  logic [ivs_pkg::IDX_W-1:0]  pos_r;
  logic [ivs_pkg::WORD_W-1:0] word_r;
  logic [ivs_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [ivs_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [ivs_pkg::WORD_W-1:0] rdata_r;
  logic [ivs_pkg::WORD_W-1:0] res_word_r;
  logic [ivs_pkg::IDX_W-1:0]  res_at_r;
  logic [ivs_pkg::ST_W-1:0]   res_st_r;
  logic                       out_valid_r;
  logic [ivs_pkg::WORD_W-1:0] out_word_r;
  logic [ivs_pkg::IDX_W-1:0]  out_at_r;
  logic [ivs_pkg::ST_W-1:0]   out_st_r;
  logic [ivs_pkg::CNT_W-1:0]  out_cnt_r;
  logic [ivs_pkg::CNT_W-1:0]  addr_full;
  logic [ivs_pkg::IDX_W-1:0]  addr;
  logic [ivs_pkg::WORD_W-1:0] wdata;
  logic [ivs_pkg::CNT_W-1:0]  idx_up;

  assign idx_up = idx_r + 1'b1;

  // Pick the single memory port address
  always_comb begin
    unique case (cmd.addr_sel)
      ivs_pkg::ADDR_POS:    addr_full = {1'b0, pos_r};
      ivs_pkg::ADDR_IDX:    addr_full = idx_r;
      ivs_pkg::ADDR_IDX_DN: addr_full = idx_r - 1'b1;
      ivs_pkg::ADDR_IDX_UP: addr_full = idx_up;
      ivs_pkg::ADDR_COUNT:  addr_full = count_r;
      ivs_pkg::ADDR_LAST:   addr_full = count_r - 1'b1;
      default:              addr_full = '0;
    endcase
  end

  assign addr  = addr_full[ivs_pkg::IDX_W-1:0];
  assign wdata = cmd.wr_from_rd ? rdata_r : word_r;

  // Entry memory: one access a cycle, read data registered
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr];
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      pos_r  <= in_position;
      word_r <= in_word_in;
    end
  end

  // Advance the live count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Load or step the walk index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_ld) begin
      unique case (cmd.idx_sel)
        ivs_pkg::IDX_FROM_POS:   idx_nxt = {1'b0, pos_r};
        ivs_pkg::IDX_FROM_COUNT: idx_nxt = count_r;
        default:                 idx_nxt = '0;
      endcase
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_up;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // Build the result of the current operation
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_word_r <= '0;
      res_at_r   <= '0;
      res_st_r   <= ivs_pkg::ST_OK;
    end else begin
      if (cmd.cap_word) begin
        res_word_r <= rdata_r;
      end
      if (cmd.set_at) begin
        res_at_r <= idx_r[ivs_pkg::IDX_W-1:0];
      end
      if (cmd.set_st) begin
        res_st_r <= cmd.st;
      end
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r <= res_word_r;
      out_at_r   <= res_at_r;
      out_st_r   <= res_st_r;
      out_cnt_r  <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_out   = out_word_r;
  assign out_found_at   = out_at_r;
  assign out_status     = out_st_r;
  assign out_live_count = out_cnt_r;

  // Status back to the controller
  always_comb begin
    sts.op       = op_r;
    sts.pos_ok   = ({1'b0, pos_r} < count_r);
    sts.empty    = (count_r == '0);
    sts.full     = (count_r >= ivs_pkg::CAP_COUNT);
    sts.idx_zero = (idx_r == '0);
    sts.idx_last = (idx_up >= count_r);
    sts.idx_end  = (idx_r >= count_r);
    sts.match    = (rdata_r == word_r);
    sts.out_busy = out_valid_r && out_stall;
  end

endmodule

[rtl/ivs_ctrl.sv]
// ivs_ctrl: operation sequencer of the indexed vector store; walks the
// entry memory for shifts, deletes and searches. Depends on ivs_pkg.
`timescale 1ns / 1ps

module ivs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ivs_pkg::ivs_sts_t sts,
  output ivs_pkg::ivs_cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_GET      = 4'd2;
  localparam logic [3:0] S_PF_RD    = 4'd3;
  localparam logic [3:0] S_PF_WR    = 4'd4;
  localparam logic [3:0] S_DEL_CAP  = 4'd5;
  localparam logic [3:0] S_DEL_RD   = 4'd6;
  localparam logic [3:0] S_DEL_WR   = 4'd7;
  localparam logic [3:0] S_FIND_RD  = 4'd8;
  localparam logic [3:0] S_FIND_CMP = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence each operation
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (sts.op)
          ivs_pkg::OP_GET: begin
            if (sts.pos_ok) begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = ivs_pkg::ADDR_POS;
              state_nxt    = S_GET;
            end else begin
              cmd.set_st = 1'b1;
              cmd.st     = ivs_pkg::ST_RANGE;
            end
          end
          ivs_pkg::OP_SET: begin
            if (sts.pos_ok) begin
              cmd.mem_wr   = 1'b1;
              cmd.addr_sel = ivs_pkg::ADDR_POS;
            end else begin
              cmd.set_st = 1'b1;
              cmd.st     = ivs_pkg::ST_RANGE;
            end
          end
          ivs_pkg::OP_PUSH_BACK: begin
            if (sts.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ivs_pkg::ST_FULL;
            end else begin
              cmd.mem_wr   = 1'b1;
              cmd.addr_sel = ivs_pkg::ADDR_COUNT;
              cmd.cnt_inc  = 1'b1;
            end
          end
          ivs_pkg::OP_PUSH_FRONT: begin
            if (sts.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ivs_pkg::ST_FULL;
            end else begin
              cmd.idx_ld  = 1'b1;
              cmd.idx_sel = ivs_pkg::IDX_FROM_COUNT;
              state_nxt   = S_PF_RD;
            end
          end
          ivs_pkg::OP_POP_BACK: begin
            if (sts.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ivs_pkg::ST_RANGE;
            end else begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = ivs_pkg::ADDR_LAST;
              cmd.cnt_dec  = 1'b1;
              state_nxt    = S_GET;
            end
          end
          ivs_pkg::OP_POP_FRONT: begin
            if (sts.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ivs_pkg::ST_RANGE;
            end else begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = ivs_pkg::ADDR_ZERO;
              cmd.idx_ld   = 1'b1;
              cmd.idx_sel  = ivs_pkg::IDX_FROM_ZERO;
              state_nxt    = S_DEL_CAP;
            end
          end
          ivs_pkg::OP_DELETE: begin
            if (sts.pos_ok) begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = ivs_pkg::ADDR_POS;
              cmd.idx_ld   = 1'b1;
              cmd.idx_sel  = ivs_pkg::IDX_FROM_POS;
              state_nxt    = S_DEL_CAP;
            end else begin
              cmd.set_st = 1'b1;
              cmd.st     = ivs_pkg::ST_RANGE;
            end
          end
          ivs_pkg::OP_FIND: begin
            cmd.set_st  = 1'b1;
            cmd.st      = ivs_pkg::ST_NOT_FOUND;
            cmd.idx_ld  = 1'b1;
            cmd.idx_sel = ivs_pkg::IDX_FROM_ZERO;
            state_nxt   = S_FIND_RD;
          end
          ivs_pkg::OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: begin
            // unused codes leave the store alone and answer ok
          end
        endcase
      end
      S_GET: begin
        cmd.cap_word = 1'b1;
        state_nxt    = S_DONE;
      end
      // Shift entries up one place, top first, then drop the word in at zero
      S_PF_RD: begin
        if (sts.idx_zero) begin
          cmd.mem_wr   = 1'b1;
          cmd.addr_sel = ivs_pkg::ADDR_IDX;
          cmd.cnt_inc  = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = ivs_pkg::ADDR_IDX_DN;
          state_nxt    = S_PF_WR;
        end
      end
      S_PF_WR: begin
        cmd.mem_wr     = 1'b1;
        cmd.addr_sel   = ivs_pkg::ADDR_IDX;
        cmd.wr_from_rd = 1'b1;
        cmd.idx_dec    = 1'b1;
        state_nxt      = S_PF_RD;
      end
      // Keep the removed entry, then close the gap upwards
      S_DEL_CAP: begin
        cmd.cap_word = 1'b1;
        state_nxt    = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (sts.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = ivs_pkg::ADDR_IDX_UP;
          state_nxt    = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.mem_wr     = 1'b1;
        cmd.addr_sel   = ivs_pkg::ADDR_IDX;
        cmd.wr_from_rd = 1'b1;
        cmd.idx_inc    = 1'b1;
        state_nxt      = S_DEL_RD;
      end
      // Search from the bottom, stop at the first match
      S_FIND_RD: begin
        if (sts.idx_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = ivs_pkg::ADDR_IDX;
          state_nxt    = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (sts.match) begin
          cmd.set_st = 1'b1;
          cmd.st     = ivs_pkg::ST_OK;
          cmd.set_at = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_FIND_RD;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
